FILE: src/task_claim_retry_dispatcher_defines.svh
// Assertion macros used by the dispatcher top level.
`ifndef TASK_CLAIM_RETRY_DISPATCHER_DEFINES_SVH
`define TASK_CLAIM_RETRY_DISPATCHER_DEFINES_SVH

// Condition and consequence in the same cycle.
`define TCRD_ASSERT_SAME(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("dispatcher assertion failed");

// Consequence in the cycle after the condition.
`define TCRD_ASSERT_NEXT(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("dispatcher assertion failed");

`endif

FILE: src/tcrd_pkg.sv
// ----------------------------------------------------------------------------
// tcrd_pkg
// Types and constants of the task claim and retry dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none
package tcrd_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int MAX_BATCH   = 16;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = 11;
	localparam int BATCH_W     = $clog2(MAX_BATCH + 1);
	localparam int RTOT_W      = 18;
	localparam int SRETRY_W    = 9;
	localparam int CFG_IDX_W   = 1;

	typedef enum logic [1:0] {
		SLOT_PENDING = 2'd0,
		SLOT_CLAIMED = 2'd1,
		SLOT_DONE    = 2'd2,
		SLOT_FAILED  = 2'd3
	} slot_state_t;

	typedef enum logic [1:0] {
		REQ_CLAIM = 2'd0,
		REQ_DONE  = 2'd1,
		REQ_ERROR = 2'd2,
		REQ_RESET = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_NONE   = 2'd1,
		STAT_BAD    = 2'd2,
		STAT_FAILED = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TASK_COUNT  = 1'd0,
		CFG_RETRY_LIMIT = 1'd1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CL_NEXT,
		S_CL_CHK,
		S_MK_CHK,
		S_RS_RD,
		S_RS_CHK,
		S_EMIT
	} fsm_t;

	typedef struct packed {
		slot_state_t         state;
		logic [SRETRY_W-1:0] retries;
		logic [7:0]          owner;
	} slot_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		slot_t             wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		status_t           status;
		logic [CNT_W-1:0]  claimed_id;
		logic [CNT_W-1:0]  reset_number;
		logic [CNT_W-1:0]  done_total;
		logic [CNT_W-1:0]  failed_total;
		logic [RTOT_W-1:0] retries_scheduled;
		logic              last;
	} res_t;

endpackage
`default_nettype wire

FILE: src/tcrd_ram.sv
// ----------------------------------------------------------------------------
// tcrd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module tcrd_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 19
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: src/tcrd_engine.sv
// ----------------------------------------------------------------------------
// tcrd_engine
// Request sequencer: read-modify-write of the slot table, counters and cursor.
// ----------------------------------------------------------------------------
`default_nettype none
module tcrd_engine import tcrd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           req_type,
	input  wire logic [7:0]           worker_num,
	input  wire logic [CNT_W-1:0]     task_id,
	input  wire logic [4:0]           claim_count,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CNT_W-1:0]     cfg_data,
	output mem_req_t                  mem_req,
	input  wire slot_t                mem_rdata,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output res_t                      res
);

	fsm_t                state_q, state_d, ret_q, ret_d;
	logic [CNT_W-1:0]    cursor_q, cursor_d, sweep_q, sweep_d, held_q, held_d;
	logic [CNT_W-1:0]    tc_q, tc_d, n_q, n_d, num_q, num_d, id_q, id_d;
	logic [CNT_W-1:0]    done_q, done_d, failed_q, failed_d;
	logic [RTOT_W-1:0]   retry_q, retry_d;
	logic [7:0]          limit_q, limit_d, worker_q, worker_d;
	logic [BATCH_W-1:0]  m_q, m_d, want_q, want_d;
	logic                have_q, have_d, last_q, last_d;
	req_t                req_q, req_d;
	status_t             stat_q, stat_d;
	logic [ADDR_W-1:0]   addr_q, addr_d;
	logic [CNT_W-1:0]    tid_m1, addr_p1;
	logic [CNT_W:0]      fin_sum;
	logic [SRETRY_W-1:0] rc;
	logic [BATCH_W-1:0]  want_c;

	assign tid_m1  = task_id - CNT_W'(1);
	assign addr_p1 = CNT_W'(addr_q) + CNT_W'(1);
	assign fin_sum = {1'b0, done_q} + {1'b0, failed_q};
	assign rc      = (mem_rdata.retries == '1) ? mem_rdata.retries
		: mem_rdata.retries + SRETRY_W'(1);

	always_comb begin
		want_c = (claim_count > 5'(MAX_BATCH)) ? BATCH_W'(MAX_BATCH) : BATCH_W'(claim_count);
		if (CNT_W'(want_c) > tc_q) begin
			want_c = BATCH_W'(tc_q);
		end
	end

	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		cursor_d = cursor_q;
		sweep_d  = sweep_q;
		held_d   = held_q;
		tc_d     = tc_q;
		n_d      = n_q;
		num_d    = num_q;
		id_d     = id_q;
		done_d   = done_q;
		failed_d = failed_q;
		retry_d  = retry_q;
		limit_d  = limit_q;
		worker_d = worker_q;
		m_d      = m_q;
		want_d   = want_q;
		have_d   = have_q;
		last_d   = last_q;
		req_d    = req_q;
		stat_d   = stat_q;
		addr_d   = addr_q;
		mem_req.we    = 1'b0;
		mem_req.waddr = addr_q;
		mem_req.wdata = '0;
		mem_req.raddr = addr_q;
		in_stall  = (state_q != S_IDLE);
		res_valid = (state_q == S_EMIT);

		case (state_q)
			S_CLEAR: begin
				mem_req.we = 1'b1;
				if (addr_q == ADDR_W'(TABLE_DEPTH - 1)) begin
					state_d = S_IDLE;
				end else begin
					addr_d = addr_q + ADDR_W'(1);
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					req_d    = req_t'(req_type);
					worker_d = worker_num;
					stat_d   = STAT_BAD;
					id_d     = '0;
					num_d    = '0;
					last_d   = 1'b1;
					ret_d    = S_IDLE;
					state_d  = S_EMIT;
					case (req_t'(req_type))
						REQ_CLAIM: begin
							if (worker_num != 8'd0 && claim_count != 5'd0) begin
								want_d  = want_c;
								m_d     = '0;
								have_d  = 1'b0;
								sweep_d = '0;
								state_d = S_CL_NEXT;
							end
						end
						REQ_RESET: begin
							if (worker_num != 8'd0) begin
								addr_d  = '0;
								n_d     = '0;
								state_d = S_RS_RD;
							end
						end
						default: begin
							if (task_id != '0 && task_id <= tc_q) begin
								mem_req.raddr = tid_m1[ADDR_W-1:0];
								addr_d        = tid_m1[ADDR_W-1:0];
								state_d       = S_MK_CHK;
							end
						end
					endcase
				end
			end
			S_CL_NEXT: begin
				if (CNT_W'(m_q) != CNT_W'(want_q) && cursor_q < tc_q) begin
					mem_req.raddr = cursor_q[ADDR_W-1:0];
					addr_d        = cursor_q[ADDR_W-1:0];
					cursor_d      = cursor_q + CNT_W'(1);
					state_d       = S_CL_CHK;
				end else if (m_q != want_q && fin_sum < {1'b0, tc_q}
						&& sweep_q < tc_q) begin
					mem_req.raddr = sweep_q[ADDR_W-1:0];
					addr_d        = sweep_q[ADDR_W-1:0];
					sweep_d       = sweep_q + CNT_W'(1);
					state_d       = S_CL_CHK;
				end else begin
					// Request finished: release the held id, if any, as the final word.
					stat_d  = have_q ? STAT_OK : STAT_NONE;
					id_d    = have_q ? held_q : '0;
					num_d   = '0;
					last_d  = 1'b1;
					ret_d   = S_IDLE;
					state_d = S_EMIT;
				end
			end
			S_CL_CHK: begin
				state_d = S_CL_NEXT;
				if (mem_rdata.state == SLOT_PENDING) begin
					mem_req.we    = 1'b1;
					mem_req.wdata = '{state: SLOT_CLAIMED, retries: mem_rdata.retries,
						owner: worker_q};
					m_d    = m_q + BATCH_W'(1);
					held_d = addr_p1;
					have_d = 1'b1;
					// The previous id is only sent once it is known not to be the last.
					if (have_q) begin
						stat_d  = STAT_OK;
						id_d    = held_q;
						num_d   = '0;
						last_d  = 1'b0;
						ret_d   = S_CL_NEXT;
						state_d = S_EMIT;
					end
				end
			end
			S_MK_CHK: begin
				mem_req.we = 1'b1;
				id_d    = '0;
				num_d   = '0;
				last_d  = 1'b1;
				ret_d   = S_IDLE;
				state_d = S_EMIT;
				if (req_q == REQ_DONE) begin
					mem_req.wdata = '{state: SLOT_DONE, retries: mem_rdata.retries,
						owner: 8'd0};
					if (done_q != '1) begin
						done_d = done_q + CNT_W'(1);
					end
					stat_d = STAT_OK;
				end else if (rc > SRETRY_W'(limit_q)) begin
					mem_req.wdata = '{state: SLOT_FAILED, retries: rc, owner: 8'd0};
					if (failed_q != '1) begin
						failed_d = failed_q + CNT_W'(1);
					end
					stat_d = STAT_FAILED;
				end else begin
					mem_req.wdata = '{state: SLOT_PENDING, retries: rc, owner: 8'd0};
					if (retry_q != '1) begin
						retry_d = retry_q + RTOT_W'(1);
					end
					stat_d = STAT_OK;
				end
			end
			S_RS_RD: begin
				state_d = S_RS_CHK;
			end
			S_RS_CHK: begin
				if (mem_rdata.state == SLOT_CLAIMED && mem_rdata.owner == worker_q) begin
					mem_req.we    = 1'b1;
					mem_req.wdata = '{state: SLOT_PENDING, retries: mem_rdata.retries,
						owner: 8'd0};
					n_d = n_q + CNT_W'(1);
				end
				if (addr_p1 == tc_q) begin
					stat_d  = STAT_OK;
					id_d    = '0;
					num_d   = n_d;
					last_d  = 1'b1;
					ret_d   = S_IDLE;
					state_d = S_EMIT;
				end else begin
					addr_d  = addr_q + ADDR_W'(1);
					state_d = S_RS_RD;
				end
			end
			S_EMIT: begin
				if (res_ready) begin
					state_d = ret_q;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TASK_COUNT: begin
					if (cfg_data == '0) begin
						tc_d = CNT_W'(1);
					end else if (cfg_data > CNT_W'(TABLE_DEPTH)) begin
						tc_d = CNT_W'(TABLE_DEPTH);
					end else begin
						tc_d = cfg_data;
					end
					cursor_d = '0;
					done_d   = '0;
					failed_d = '0;
					retry_d  = '0;
					addr_d   = '0;
					state_d  = S_CLEAR;
				end
				CFG_RETRY_LIMIT: begin
					limit_d = cfg_data[7:0];
				end
				default: begin
					limit_d = limit_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			ret_q    <= S_IDLE;
			addr_q   <= '0;
			cursor_q <= '0;
			done_q   <= '0;
			failed_q <= '0;
			retry_q  <= '0;
			tc_q     <= CNT_W'(1);
			limit_q  <= '0;
		end else begin
			state_q  <= state_d;
			ret_q    <= ret_d;
			addr_q   <= addr_d;
			cursor_q <= cursor_d;
			done_q   <= done_d;
			failed_q <= failed_d;
			retry_q  <= retry_d;
			tc_q     <= tc_d;
			limit_q  <= limit_d;
		end
	end

	always_ff @(posedge clk) begin
		sweep_q  <= sweep_d;
		held_q   <= held_d;
		n_q      <= n_d;
		num_q    <= num_d;
		id_q     <= id_d;
		worker_q <= worker_d;
		m_q      <= m_d;
		want_q   <= want_d;
		have_q   <= have_d;
		last_q   <= last_d;
		req_q    <= req_d;
		stat_q   <= stat_d;
	end

	assign res = '{status: stat_q, claimed_id: id_q, reset_number: num_q,
		done_total: done_q, failed_total: failed_q, retries_scheduled: retry_q,
		last: last_q};

endmodule
`default_nettype wire

FILE: src/task_claim_retry_dispatcher.sv
// ----------------------------------------------------------------------------
// task_claim_retry_dispatcher
// Task slot table with claim, done, error and reset-claims requests.
// ----------------------------------------------------------------------------
// Channel  Handshake          Payload
// in       in_valid/in_stall  req_type worker_num task_id claim_count
// out      out_valid/out_stall status claimed_id reset_number totals last
// cfg      cfg_we             cfg_index cfg_data
//
// A mark request holds the input through accept, table read-modify-write and
// result; a rejected request goes from accept straight to result. A claim examines
// slots one at a time, each a table read and, for a pending slot, a write, plus a
// result word per claimed id and the accept and closing steps. Reset-claims walks
// the table slot by slot over the slots in use, plus accept and result.
// After reset and after each task_count write the table is cleared, all 1024 entries,
// during which in_stall is high.
// A stalled result sits in the output register and holds the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "task_claim_retry_dispatcher_defines.svh"
module task_claim_retry_dispatcher import tcrd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           req_type,
	input  wire logic [7:0]           worker_num,
	input  wire logic [CNT_W-1:0]     task_id,
	input  wire logic [4:0]           claim_count,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [1:0]                status,
	output logic [CNT_W-1:0]          claimed_id,
	output logic [CNT_W-1:0]          reset_number,
	output logic [CNT_W-1:0]          done_total,
	output logic [CNT_W-1:0]          failed_total,
	output logic [RTOT_W-1:0]         retries_scheduled,
	output logic                      last,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CNT_W-1:0]     cfg_data
);

	mem_req_t mem_req;
	slot_t    mem_rdata;
	logic     res_valid, res_ready, out_valid_q;
	res_t     res, out_q;

	tcrd_ram #(.DEPTH(TABLE_DEPTH), .WIDTH($bits(slot_t))) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	tcrd_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.worker_num  (worker_num),
		.task_id     (task_id),
		.claim_count (claim_count),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mem_req     (mem_req),
		.mem_rdata   (mem_rdata),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// The output register frees as its word is taken.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = out_q.status;
	assign claimed_id        = out_q.claimed_id;
	assign reset_number      = out_q.reset_number;
	assign done_total        = out_q.done_total;
	assign failed_total      = out_q.failed_total;
	assign retries_scheduled = out_q.retries_scheduled;
	assign last              = out_q.last;

	`TCRD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`TCRD_ASSERT_SAME(a_none_is_final, out_valid && status == STAT_NONE,
		claimed_id == '0 && last)
	`TCRD_ASSERT_SAME(a_id_means_ok, out_valid && claimed_id != '0, status == STAT_OK)

endmodule
`default_nettype wire
